/* hw/rtl/tlb_pkg.sv */
// ----------------------------------------------------------------------------
// tlb package
// Types, field widths and codes shared by the translation buffer, its checker and testbench.
// ----------------------------------------------------------------------------
package tlb_pkg;

   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 20;
   localparam int AGE_BITS   = 16;
   localparam int LFSR_BITS  = 16;
   localparam int SLOT_BITS  = 2;

   localparam logic [AGE_BITS-1:0]  AGE_MAX   = 16'hFFFF;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

   // replacement policy codes
   localparam logic [1:0] POL_FIFO   = 2'd0;
   localparam logic [1:0] POL_LRU    = 2'd1;
   localparam logic [1:0] POL_RANDOM = 2'd2;

   // request kinds
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_FILL   = 1'b1;

   typedef struct packed {
      logic                  req_type;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
   } req_payload_type;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame_out;
      logic [SLOT_BITS-1:0]  slot;
      logic                  evicted;
   } rsp_payload_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
      logic [AGE_BITS-1:0]   age;
   } entry_type;

endpackage

/* hw/rtl/tlb_ram.sv */
// ----------------------------------------------------------------------------
// tlb generic ram
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tlb_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tlb_with_replacement_policies.sv */
// ----------------------------------------------------------------------------
// fully associative tlb with fifo, lru and random replacement
// Sequencer around one entry RAM; one request is handled at a time.
// ----------------------------------------------------------------------------
// Steps per transaction: a lookup scans the filled entries in order and, on a hit, runs an
// update pass over the filled entries; a lookup in an empty table goes straight to the response
// (each entry is a ram read then a compare or write); a fill with room runs an update pass that
// writes the new entry; full fill: fifo a shift pass, lru an age search then update, random one write.
// One transaction at a time; the next request is taken after the response.
// Reset: policy LRU, lfsr 0xACE1, fill count zero; no RAM clearing pass.
module tlb_with_replacement_policies #(
   parameter int ENTRIES = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tlb_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tlb_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_data
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ENT_W   = $bits(tlb_pkg::entry_type);
   localparam int RECIP_SHIFT = tlb_pkg::LFSR_BITS + IDX_W;
   localparam int PROD_W  = RECIP_SHIFT + tlb_pkg::LFSR_BITS;
   // rounded-up reciprocal, exact quotient for any lfsr value
   localparam int RECIP   = ((1 << RECIP_SHIFT) + ENTRIES - 1) / ENTRIES;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN_RD  = 9'b000000010,
      S_SCAN_CHK = 9'b000000100,
      S_MAX_RD   = 9'b000001000,
      S_MAX_CHK  = 9'b000010000,
      S_MOD      = 9'b000100000,
      S_UPD_RD   = 9'b001000000,
      S_UPD_WR   = 9'b010000000,
      S_RESP     = 9'b100000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       policy_ff, policy_in;
   logic [CNT_W-1:0]                 fill_count_ff, fill_count_in;
   logic [tlb_pkg::LFSR_BITS-1:0]    lfsr_ff, lfsr_in;
   tlb_pkg::req_payload_type         req_ff, req_in;
   logic                             hit_ff, hit_in;
   logic [tlb_pkg::FRAME_BITS-1:0]   frame_out_ff, frame_out_in;
   logic [IDX_W-1:0]                 slot_ff, slot_in;
   logic                             evicted_ff, evicted_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 last_ff, last_in;
   logic                             age_en_ff, age_en_in;
   logic                             wr_new_ff, wr_new_in;
   logic                             shift_ff, shift_in;
   logic [tlb_pkg::AGE_BITS-1:0]     best_ff, best_in;
   logic [tlb_pkg::LFSR_BITS-1:0]    rem_ff, rem_in;
   logic                             k_ff, k_in;

   logic                             ram_wr_en;
   logic                             ram_rd_en;
   logic [IDX_W-1:0]                 ram_rd_addr;
   logic [ENT_W-1:0]                 ram_rd_data;
   tlb_pkg::entry_type               rd_entry;
   tlb_pkg::entry_type               wr_entry;
   logic [tlb_pkg::LFSR_BITS-1:0]    lfsr_step;
   logic [PROD_W-1:0]                recip_prod;
   logic [tlb_pkg::LFSR_BITS-1:0]    rem_step;
   logic [tlb_pkg::AGE_BITS-1:0]     age_sat;
   logic [IDX_W+1:0]                 slot_ext;
   logic [IDX_W-1:0]                 idx_inc;

   tlb_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = tlb_pkg::entry_type'(ram_rd_data);
   assign idx_inc  = IDX_W'(idx_ff + 1'b1);

   // fibonacci lfsr, taps 16 14 13 11
   assign lfsr_step = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};

   // victim is the stepped lfsr modulo ENTRIES: quotient first, remainder next cycle
   assign recip_prod = PROD_W'(lfsr_ff) * PROD_W'(RECIP);
   assign rem_step   = lfsr_ff - tlb_pkg::LFSR_BITS'(rem_ff * tlb_pkg::LFSR_BITS'(ENTRIES));

   assign age_sat = (rd_entry.age == tlb_pkg::AGE_MAX) ? rd_entry.age
                                                       : tlb_pkg::AGE_BITS'(rd_entry.age + 1'b1);

   // in a shift pass each slot takes the contents of the one above it
   assign ram_rd_addr = (state_ff == S_UPD_RD && shift_ff && idx_ff != last_ff) ? idx_inc
                                                                                : idx_ff;
   assign ram_rd_en   = (state_ff == S_SCAN_RD) || (state_ff == S_MAX_RD) ||
                        (state_ff == S_UPD_RD);
   assign ram_wr_en   = (state_ff == S_UPD_WR);

   always_comb begin
      if (idx_ff == slot_ff && wr_new_ff) begin
         wr_entry.page  = req_ff.page;
         wr_entry.frame = req_ff.frame;
         wr_entry.age   = '0;
      end else if (idx_ff == slot_ff) begin
         wr_entry.page  = rd_entry.page;
         wr_entry.frame = rd_entry.frame;
         wr_entry.age   = '0;
      end else begin
         wr_entry.page  = rd_entry.page;
         wr_entry.frame = rd_entry.frame;
         wr_entry.age   = age_en_ff ? age_sat : rd_entry.age;
      end
   end

   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      fill_count_in = fill_count_ff;
      lfsr_in       = lfsr_ff;
      req_in        = req_ff;
      hit_in        = hit_ff;
      frame_out_in  = frame_out_ff;
      slot_in       = slot_ff;
      evicted_in    = evicted_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      age_en_in     = age_en_ff;
      wr_new_in     = wr_new_ff;
      shift_in      = shift_ff;
      best_in       = best_ff;
      rem_in        = rem_ff;
      k_in          = k_ff;

      if (csr_valid) begin
         policy_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req_payload;
               hit_in       = 1'b0;
               frame_out_in = '0;
               slot_in      = '0;
               evicted_in   = 1'b0;
               idx_in       = '0;
               age_en_in    = 1'b1;
               wr_new_in    = 1'b1;
               shift_in     = 1'b0;
               if (req_payload.req_type == tlb_pkg::REQ_LOOKUP) begin
                  wr_new_in = 1'b0;
                  if (fill_count_ff == '0) begin
                     state_in = S_RESP;
                  end else begin
                     last_in  = IDX_W'(fill_count_ff - 1'b1);
                     state_in = S_SCAN_RD;
                  end
               end else if (fill_count_ff != FULL_CNT) begin
                  slot_in       = fill_count_ff[IDX_W-1:0];
                  last_in       = fill_count_ff[IDX_W-1:0];
                  fill_count_in = CNT_W'(fill_count_ff + 1'b1);
                  state_in      = S_UPD_RD;
               end else begin
                  evicted_in = 1'b1;
                  unique case (policy_ff)
                     tlb_pkg::POL_FIFO: begin
                        shift_in  = 1'b1;
                        age_en_in = 1'b0;
                        slot_in   = LAST_IDX;
                        last_in   = LAST_IDX;
                        state_in  = S_UPD_RD;
                     end
                     tlb_pkg::POL_RANDOM: begin
                        lfsr_in   = lfsr_step;
                        k_in      = 1'b0;
                        age_en_in = 1'b0;
                        state_in  = S_MOD;
                     end
                     default: begin
                        // lru, and the unused code behaves the same
                        best_in  = '0;
                        last_in  = LAST_IDX;
                        state_in = S_MAX_RD;
                     end
                  endcase
               end
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (rd_entry.page == req_ff.page) begin
               hit_in       = 1'b1;
               frame_out_in = rd_entry.frame;
               slot_in      = idx_ff;
               idx_in       = '0;
               state_in     = S_UPD_RD;
            end else if (idx_ff == last_ff) begin
               state_in = S_RESP;
            end else begin
               idx_in   = idx_inc;
               state_in = S_SCAN_RD;
            end
         end
         S_MAX_RD: begin
            state_in = S_MAX_CHK;
         end
         S_MAX_CHK: begin
            // strict compare keeps the first slot holding the largest age
            if (rd_entry.age > best_ff) begin
               best_in = rd_entry.age;
               slot_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = S_UPD_RD;
            end else begin
               idx_in   = idx_inc;
               state_in = S_MAX_RD;
            end
         end
         S_MOD: begin
            if (!k_ff) begin
               rem_in = recip_prod[RECIP_SHIFT +: tlb_pkg::LFSR_BITS];
               k_in   = 1'b1;
            end else begin
               slot_in  = rem_step[IDX_W-1:0];
               idx_in   = rem_step[IDX_W-1:0];
               last_in  = rem_step[IDX_W-1:0];
               state_in = S_UPD_RD;
            end
         end
         S_UPD_RD: begin
            state_in = S_UPD_WR;
         end
         S_UPD_WR: begin
            if (idx_ff == last_ff) begin
               state_in = S_RESP;
            end else begin
               idx_in   = idx_inc;
               state_in = S_UPD_RD;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         policy_ff     <= tlb_pkg::POL_LRU;
         fill_count_ff <= '0;
         lfsr_ff       <= tlb_pkg::LFSR_SEED;
      end else begin
         state_ff      <= state_in;
         policy_ff     <= policy_in;
         fill_count_ff <= fill_count_in;
         lfsr_ff       <= lfsr_in;
      end
      req_ff       <= req_in;
      hit_ff       <= hit_in;
      frame_out_ff <= frame_out_in;
      slot_ff      <= slot_in;
      evicted_ff   <= evicted_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      age_en_ff    <= age_en_in;
      wr_new_ff    <= wr_new_in;
      shift_ff     <= shift_in;
      best_ff      <= best_in;
      rem_ff       <= rem_in;
      k_ff         <= k_in;
   end

   assign slot_ext = {2'b00, slot_ff};

   assign req_ready             = (state_ff == S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = (state_ff == S_RESP);
   assign rsp_payload.hit       = hit_ff;
   assign rsp_payload.frame_out = frame_out_ff;
   assign rsp_payload.slot      = slot_ext[tlb_pkg::SLOT_BITS-1:0];
   assign rsp_payload.evicted   = evicted_ff;

endmodule

/* test/tlb_checker.sv */
// ----------------------------------------------------------------------------
// tlb checker
// Watches the request, response and register channels of the translation
// buffer, predicts every response from its own copy of the table, ages and
// policy, and compares the responses in order, field by field.
// ----------------------------------------------------------------------------
module tlb_checker
   import tlb_pkg::*;
#(
   parameter int ENTRIES = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [1:0]      csr_data,
   output int              outstanding,
   output int              failures
);

   timeunit 1ns;
   timeprecision 1ps;

   logic [PAGE_BITS-1:0]  tlb_page  [ENTRIES];
   logic [FRAME_BITS-1:0] tlb_frame [ENTRIES];
   logic [AGE_BITS-1:0]   tlb_age   [ENTRIES];
   int                    fill_level;
   logic [LFSR_BITS-1:0]  victim_lfsr;
   logic [1:0]            policy;

   rsp_payload_type pending_translations [$];
   int              fail_tally = 0;

   assign failures = fail_tally;

   // every valid entry except skip grows older, stopping at the maximum
   function automatic void age_all_but(int skip);
      for (int m = 0; m < fill_level; m++) begin
         if (m != skip && tlb_age[m] != AGE_MAX) begin
            tlb_age[m] = tlb_age[m] + 1'b1;
         end
      end
   endfunction

   function automatic rsp_payload_type translate_request(req_payload_type r);
      rsp_payload_type      o;
      int                   victim;
      logic [AGE_BITS-1:0]  oldest;
      logic                 found;
      logic                 feedback;
      o = '0;
      found = 1'b0;
      victim = 0;
      if (r.req_type == REQ_LOOKUP) begin
         for (int i = 0; i < fill_level; i++) begin
            if (!found && tlb_page[i] == r.page) begin
               found = 1'b1;
               victim = i;
            end
         end
         if (found) begin
            o.hit = 1'b1;
            o.frame_out = tlb_frame[victim];
            o.slot = SLOT_BITS'(victim);
            tlb_age[victim] = '0;
            age_all_but(victim);
         end
      end else if (fill_level < ENTRIES) begin
         victim = fill_level;
         tlb_page[victim] = r.page;
         tlb_frame[victim] = r.frame;
         tlb_age[victim] = '0;
         age_all_but(victim);
         fill_level = fill_level + 1;
         o.slot = SLOT_BITS'(victim);
      end else begin
         o.evicted = 1'b1;
         if (policy == POL_FIFO) begin
            // shift down, ages travel with their entries
            for (int i = 0; i < ENTRIES - 1; i++) begin
               tlb_page[i] = tlb_page[i+1];
               tlb_frame[i] = tlb_frame[i+1];
               tlb_age[i] = tlb_age[i+1];
            end
            victim = ENTRIES - 1;
            tlb_page[victim] = r.page;
            tlb_frame[victim] = r.frame;
            tlb_age[victim] = '0;
         end else if (policy == POL_RANDOM) begin
            feedback = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
            victim_lfsr = {feedback, victim_lfsr[LFSR_BITS-1:1]};
            victim = int'(victim_lfsr) % ENTRIES;
            tlb_page[victim] = r.page;
            tlb_frame[victim] = r.frame;
            tlb_age[victim] = '0;
         end else begin
            // least recently used, also taken for the unused code
            oldest = '0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (tlb_age[i] > oldest) begin
                  oldest = tlb_age[i];
                  victim = i;
               end
            end
            tlb_page[victim] = r.page;
            tlb_frame[victim] = r.frame;
            tlb_age[victim] = '0;
            age_all_but(victim);
         end
         o.slot = SLOT_BITS'(victim);
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int              delta;
      delta = 0;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            tlb_age[i] = '0;
            tlb_page[i] = '0;
            tlb_frame[i] = '0;
         end
         fill_level = 0;
         victim_lfsr = LFSR_SEED;
         policy = POL_LRU;
         pending_translations.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            policy = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_translations.size() == 0) begin
               $error("response transaction with no translation pending");
               fail_tally++;
            end else begin
               want = pending_translations.pop_front();
               delta = delta - 1;
               if (rsp_payload.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_payload.hit);
                  fail_tally++;
               end
               if (rsp_payload.frame_out !== want.frame_out) begin
                  $error("frame_out: expected %05h, got %05h",
                         want.frame_out, rsp_payload.frame_out);
                  fail_tally++;
               end
               if (rsp_payload.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_payload.slot);
                  fail_tally++;
               end
               if (rsp_payload.evicted !== want.evicted) begin
                  $error("evicted: expected %0d, got %0d",
                         want.evicted, rsp_payload.evicted);
                  fail_tally++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_translations.insert(pending_translations.size(),
                                        translate_request(req_payload));
            delta = delta + 1;
         end
         outstanding <= outstanding + delta;
      end
   end

endmodule

/* test/tlb_with_replacement_policies_tb.sv */
// ----------------------------------------------------------------------------
// tlb testbench
// Drives lookups and fills into the translation buffer under every
// replacement policy, with random gaps on the request channel, back-pressure
// on the response channel and long response stalls; the checker reports failures.
// ----------------------------------------------------------------------------
module tlb_with_replacement_policies_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import tlb_pkg::*;

   localparam int         ENTRIES       = 4;
   localparam int         CYCLE_LIMIT   = 4000000;
   localparam int         CHUNKS        = 14;
   localparam int         CHUNK_ITEMS   = 75;
   localparam int         STALL_CYCLES  = 400;
   localparam logic [1:0] POL_UNDEFINED = 2'd3;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_data;

   int outstanding;
   int failures;
   int req_idle_pct;
   int rsp_idle_pct;
   int stall_asked;
   int stall_served = 0;
   int stall_left = 0;
   int cycle_count = 0;

   logic [PAGE_BITS-1:0] page_pool [6];

   always #10 clock = ~clock;

   tlb_with_replacement_policies #(
      .ENTRIES (ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   tlb_checker #(
      .ENTRIES (ENTRIES)
   ) translation_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response side: random back-pressure, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (stall_served != stall_asked) begin
         rsp_ready <= 1'b0;
         stall_served = stall_served + 1;
         stall_left = STALL_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic req_payload_type make_req(logic kind, logic [PAGE_BITS-1:0] pg,
                                                logic [FRAME_BITS-1:0] fr);
      req_payload_type r;
      r.req_type = kind;
      r.page = pg;
      r.frame = fr;
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int              pick;
      r.req_type = ($urandom_range(0, 99) < 55) ? REQ_LOOKUP : REQ_FILL;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         r.page = page_pool[$urandom_range(0, 5)];
      end else if (pick < 88) begin
         r.page = $urandom_range(0, 1) ? {PAGE_BITS{1'b1}} : '0;
      end else begin
         r.page = PAGE_BITS'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         r.frame = '0;
      end else if (pick < 10) begin
         r.frame = {FRAME_BITS{1'b1}};
      end else begin
         r.frame = FRAME_BITS'($urandom);
      end
      return r;
   endfunction

   task automatic offer_request(req_payload_type r);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and let every pending transaction drain
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_policy(logic [1:0] code);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_data <= POL_FIFO;
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      stall_asked <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // policy is lru out of reset; repeated hits on slot 0 leave slot 1 the oldest
      offer_request(make_req(REQ_LOOKUP, 20'h00000, 20'hFFFFF));
      offer_request(make_req(REQ_FILL, 20'h00000, 20'hFFFFF));
      offer_request(make_req(REQ_FILL, 20'hFFFFF, 20'h00000));
      repeat (24) offer_request(make_req(REQ_LOOKUP, 20'h00000, FRAME_BITS'($urandom)));
      offer_request(make_req(REQ_FILL, 20'h5A5A5, 20'hA5A5A));
      offer_request(make_req(REQ_FILL, 20'h0F0F0, 20'hF0F0F));
      offer_request(make_req(REQ_FILL, 20'h80001, 20'h7FFFE));
      offer_request(make_req(REQ_LOOKUP, 20'hFFFFF, 20'h00000));
      offer_request(make_req(REQ_LOOKUP, 20'h80001, 20'hFFFFF));
      offer_request(make_req(REQ_LOOKUP, 20'h0F0F0, 20'h00000));
      offer_request(make_req(REQ_LOOKUP, 20'h00000, 20'h00000));

      wait_for_quiet();
      write_policy(POL_FIFO);
      offer_request(make_req(REQ_FILL, 20'h12345, 20'h6789A));
      // same page stored twice, lookup must find the lower slot
      offer_request(make_req(REQ_FILL, 20'h12345, 20'h11111));
      offer_request(make_req(REQ_LOOKUP, 20'h12345, 20'h00000));
      offer_request(make_req(REQ_LOOKUP, 20'h00000, 20'h00000));

      wait_for_quiet();
      write_policy(POL_RANDOM);
      offer_request(make_req(REQ_FILL, 20'h33333, 20'h00001));
      offer_request(make_req(REQ_FILL, 20'h44444, 20'h00002));
      offer_request(make_req(REQ_FILL, 20'h55555, 20'h00003));
      offer_request(make_req(REQ_LOOKUP, 20'h44444, 20'h00000));

      wait_for_quiet();
      write_policy(POL_UNDEFINED);
      offer_request(make_req(REQ_FILL, 20'h66666, 20'hCCCCC));
      offer_request(make_req(REQ_LOOKUP, 20'h66666, 20'h00000));

      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
         wait_for_quiet();
         if (chunk < 5) begin
            req_idle_pct <= 20;
            rsp_idle_pct <= 75;
         end else if (chunk < 10) begin
            req_idle_pct <= 75;
            rsp_idle_pct <= 20;
         end else begin
            req_idle_pct <= 0;
            rsp_idle_pct <= 0;
         end
         case (chunk % 4)
            0: write_policy(POL_FIFO);
            1: write_policy(POL_LRU);
            2: write_policy(POL_RANDOM);
            default: write_policy(POL_UNDEFINED);
         endcase
         for (int k = 0; k < 6; k++) begin
            page_pool[k] = PAGE_BITS'($urandom);
         end
         if (chunk == 1 || chunk == 11) begin
            stall_asked <= stall_asked + 1;
         end
         for (int n = 0; n < CHUNK_ITEMS; n++) begin
            if ($urandom_range(0, 59) == 0) begin
               wait_for_quiet();
            end
            offer_request(random_request());
         end
      end

      wait_for_quiet();
      repeat (40) @(posedge clock);
      if (failures == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_ram.sv
hw/rtl/tlb_with_replacement_policies.sv
test/tlb_checker.sv
test/tlb_with_replacement_policies_tb.sv
